@@ hw/rtl/tcc_pkg.sv @@
// Shared constants, codes and types of the text console cursor engine
`timescale 1ns / 1ps

package tcc_pkg;

  // grid geometry
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 128;
  localparam int TAB_STOP = 8;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int TAB_W    = $clog2(TAB_STOP);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_CHUNK = 2'd2;

  localparam logic [COL_W:0] COLUMNS_RST = 9'd80;
  localparam logic [ROW_W:0] ROWS_RST    = 8'd25;
  localparam logic [ROW_W:0] CHUNK_RST   = 8'd3;

  // commands and byte codes
  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_READ  = 1'b1;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] BLANK     = 8'h20;

  // event kinds
  localparam logic [1:0] EV_CELL   = 2'd0;
  localparam logic [1:0] EV_SCROLL = 2'd1;
  localparam logic [1:0] EV_READ   = 2'd2;

  // effective (saturated) configuration
  typedef struct packed {
    logic [COL_W:0] cols;
    logic [ROW_W:0] rows;
    logic [ROW_W:0] chunk;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic             command;
    logic [7:0]       data_byte;
    logic [COL_W-1:0] read_col;
    logic [ROW_W-1:0] read_row;
  } item_t;

  // one result item
  typedef struct packed {
    logic [1:0]       event_kind;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic [7:0]       cell_char;
    logic [ROW_W:0]   rows_scrolled;
    logic [COL_W:0]   cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             last;
  } evt_t;

  // row table entry: physical grid row and count of written leading cells
  typedef struct packed {
    logic [ROW_W-1:0] phys;
    logic [COL_W:0]   hw;
  } rt_entry_t;

endpackage

@@ hw/rtl/tcc_in_if.sv @@
// Input channel of the text console cursor engine
`timescale 1ns / 1ps

interface tcc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic [7:0] read_col;
  logic [6:0] read_row;

  modport source (output valid, output command, output data_byte, output read_col,
                  output read_row, input ready);
  modport sink (input valid, input command, input data_byte, input read_col,
                input read_row, output ready);
endinterface

@@ hw/rtl/tcc_out_if.sv @@
// Result channel of the text console cursor engine
`timescale 1ns / 1ps

interface tcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] cell_col;
  logic [6:0] cell_row;
  logic [7:0] cell_char;
  logic [7:0] rows_scrolled;
  logic [8:0] cursor_col;
  logic [6:0] cursor_row;
  logic       last;

  modport source (output valid, output event_kind, output cell_col, output cell_row,
                  output cell_char, output rows_scrolled, output cursor_col,
                  output cursor_row, output last, input ready);
  modport sink (input valid, input event_kind, input cell_col, input cell_row,
                input cell_char, input rows_scrolled, input cursor_col,
                input cursor_row, input last, output ready);
endinterface

@@ hw/rtl/tcc_core.sv @@
// Command sequencer with the row table memory and the character grid memory
`timescale 1ns / 1ps

module tcc_core (
  input  logic           clk,
  input  logic           rst_n,
  input  tcc_pkg::cfg_t  cfg,
  input  logic           item_valid,
  output logic           item_ready,
  input  tcc_pkg::item_t item,
  output logic           evt_valid,
  input  logic           evt_ready,
  output tcc_pkg::evt_t  evt
);
  import tcc_pkg::*;

  localparam int RT_DEPTH   = 2 * MAX_ROWS;
  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int GRID_AW    = ROW_W + COL_W;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_STORE    = 4'd2;
  localparam logic [3:0] ST_SCROLL   = 4'd3;
  localparam logic [3:0] ST_SWEEP    = 4'd4;
  localparam logic [3:0] ST_CELL_ROW = 4'd5;
  localparam logic [3:0] ST_FILL     = 4'd6;
  localparam logic [3:0] ST_CELL_EV  = 4'd7;
  localparam logic [3:0] ST_RD_ROW   = 4'd8;
  localparam logic [3:0] ST_RD_CELL  = 4'd9;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
  localparam logic [TAB_W-1:0] TAB_LAST = TAB_W'(TAB_STOP - 1);

  logic [3:0]       state_r, state_nxt;
  logic [COL_W:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic             bank_r, bank_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic             tab_r, tab_nxt;
  logic [TAB_W-1:0] tab_cnt_r, tab_cnt_nxt;
  logic             cont_store_r, cont_store_nxt;
  logic [COL_W-1:0] rd_col_r, rd_col_nxt;
  logic [ROW_W-1:0] rd_row_r, rd_row_nxt;
  logic             rd_hit_r, rd_hit_nxt;
  logic [ROW_W-1:0] phys_r, phys_nxt;
  logic [COL_W:0]   fill_ptr_r, fill_ptr_nxt;
  logic [ROW_W:0]   sweep_r, sweep_nxt;
  logic [ROW_W-1:0] clr_r, clr_nxt;

  // row table: two banks, logical row to physical row plus written length
  rt_entry_t        rt_mem [0:RT_DEPTH-1];
  rt_entry_t        rt_rd_r, rt_wd;
  logic             rt_re, rt_we;
  logic [ROW_W:0]   rt_ra, rt_wa;

  // character grid, fixed stride of MAX_COLS cells per physical row
  logic [7:0]         grid_mem [0:GRID_DEPTH-1];
  logic [7:0]         grid_rd_r, grid_wd;
  logic               grid_re, grid_we;
  logic [GRID_AW-1:0] grid_ra, grid_wa;

  // helper values
  logic [ROW_W-1:0] row_c;
  logic [COL_W:0]   col_c;
  logic [ROW_W:0]   row_c_inc, row_inc, scroll_base;
  logic [COL_W:0]   col_inc;
  logic             tab_done;
  logic [ROW_W+1:0] sweep_sum;
  logic [ROW_W-1:0] sweep_src, sweep_dst;
  logic             sweep_freed;
  logic             rd_hit;

  // cursor saturated into the area in use
  always_comb begin
    row_c = ({1'b0, cur_row_r} >= cfg.rows) ? ROW_W'(cfg.rows - 1'b1) : cur_row_r;
    col_c = (cur_col_r > cfg.cols) ? cfg.cols : cur_col_r;
    row_c_inc = {1'b0, row_c} + 1'b1;
    row_inc = {1'b0, cur_row_r} + 1'b1;
    scroll_base = cfg.rows - cfg.chunk;
    col_inc = cur_col_r + 1'b1;
    tab_done = (col_inc[TAB_W-1:0] == '0) || (tab_cnt_r == TAB_LAST);
  end

  // scroll sweep: rotate the rows in use by the chunk, others copied as is
  always_comb begin
    sweep_sum = {1'b0, sweep_r} + {1'b0, cfg.chunk};
    if (sweep_r < cfg.rows) begin
      if (sweep_sum >= {1'b0, cfg.rows}) begin
        sweep_src = ROW_W'(sweep_sum - {1'b0, cfg.rows});
      end else begin
        sweep_src = ROW_W'(sweep_sum);
      end
    end else begin
      sweep_src = sweep_r[ROW_W-1:0];
    end
    sweep_dst = ROW_W'(sweep_r - 1'b1);
    sweep_freed = ({1'b0, sweep_dst} >= scroll_base) && ({1'b0, sweep_dst} < cfg.rows);
  end

  // read hit: inside the area in use and inside the written part of the row
  always_comb begin
    rd_hit = ({1'b0, rd_row_r} < cfg.rows) && ({1'b0, rd_col_r} < cfg.cols) &&
             ({1'b0, rd_col_r} < rt_rd_r.hw);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    bank_nxt       = bank_r;
    ch_nxt         = ch_r;
    tab_nxt        = tab_r;
    tab_cnt_nxt    = tab_cnt_r;
    cont_store_nxt = cont_store_r;
    rd_col_nxt     = rd_col_r;
    rd_row_nxt     = rd_row_r;
    rd_hit_nxt     = rd_hit_r;
    phys_nxt       = phys_r;
    fill_ptr_nxt   = fill_ptr_r;
    sweep_nxt      = sweep_r;
    clr_nxt        = clr_r;
    rt_re          = 1'b0;
    rt_ra          = '0;
    rt_we          = 1'b0;
    rt_wa          = '0;
    rt_wd          = '0;
    grid_re        = 1'b0;
    grid_ra        = '0;
    grid_we        = 1'b0;
    grid_wa        = '0;
    grid_wd        = '0;
    item_ready     = 1'b0;
    evt_valid      = 1'b0;
    evt            = '0;

    case (state_r)
      ST_CLEAR: begin
        // identity map with empty rows in bank zero
        rt_we    = 1'b1;
        rt_wa    = {1'b0, clr_r};
        rt_wd.phys = clr_r;
        rt_wd.hw   = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == ROW_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item.command == CMD_READ) begin
            rd_col_nxt = item.read_col;
            rd_row_nxt = item.read_row;
            rt_re      = 1'b1;
            rt_ra      = {bank_r, item.read_row};
            state_nxt  = ST_RD_ROW;
          end else begin
            cur_row_nxt = row_c;
            cur_col_nxt = col_c;
            case (item.data_byte)
              CH_LF: begin
                if (row_c_inc < cfg.rows) begin
                  cur_row_nxt = ROW_W'(row_c_inc);
                  cur_col_nxt = '0;
                end else begin
                  cont_store_nxt = 1'b0;
                  state_nxt      = ST_SCROLL;
                end
              end
              CH_CR: begin
                cur_col_nxt = '0;
              end
              CH_BS: begin
                if (col_c != '0) begin
                  cur_col_nxt = col_c - 1'b1;
                end
              end
              CH_HT: begin
                ch_nxt      = BLANK;
                tab_nxt     = 1'b1;
                tab_cnt_nxt = '0;
                state_nxt   = ST_STORE;
              end
              default: begin
                if (item.data_byte >= BLANK || item.data_byte == CH_NUL) begin
                  ch_nxt    = item.data_byte;
                  tab_nxt   = 1'b0;
                  state_nxt = ST_STORE;
                end
              end
            endcase
          end
        end
      end

      ST_STORE: begin
        // wrap past the last column before the cell is placed
        if (cur_col_r >= cfg.cols) begin
          if (row_inc < cfg.rows) begin
            cur_row_nxt = ROW_W'(row_inc);
            cur_col_nxt = '0;
            rt_re       = 1'b1;
            rt_ra       = {bank_r, ROW_W'(row_inc)};
            state_nxt   = ST_CELL_ROW;
          end else begin
            cont_store_nxt = 1'b1;
            state_nxt      = ST_SCROLL;
          end
        end else begin
          rt_re     = 1'b1;
          rt_ra     = {bank_r, cur_row_r};
          state_nxt = ST_CELL_ROW;
        end
      end

      ST_SCROLL: begin
        evt_valid         = 1'b1;
        evt.event_kind    = EV_SCROLL;
        evt.rows_scrolled = cfg.chunk;
        evt.cursor_col    = '0;
        evt.cursor_row    = ROW_W'(scroll_base);
        evt.last          = !cont_store_r;
        if (evt_ready) begin
          cur_col_nxt = '0;
          cur_row_nxt = ROW_W'(scroll_base);
          sweep_nxt   = '0;
          state_nxt   = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        // read old bank at step i, write new bank at step i-1
        if (!sweep_r[ROW_W]) begin
          rt_re = 1'b1;
          rt_ra = {bank_r, sweep_src};
        end
        if (sweep_r != '0) begin
          rt_we    = 1'b1;
          rt_wa    = {!bank_r, sweep_dst};
          rt_wd.phys = rt_rd_r.phys;
          rt_wd.hw   = sweep_freed ? '0 : rt_rd_r.hw;
        end
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r[ROW_W]) begin
          bank_nxt  = !bank_r;
          state_nxt = cont_store_r ? ST_STORE : ST_IDLE;
        end
      end

      ST_CELL_ROW: begin
        phys_nxt     = rt_rd_r.phys;
        fill_ptr_nxt = rt_rd_r.hw;
        state_nxt    = ST_FILL;
      end

      ST_FILL: begin
        // blank any gap before the cursor, then store the byte
        grid_we = 1'b1;
        if (fill_ptr_r < cur_col_r) begin
          grid_wa      = {phys_r, fill_ptr_r[COL_W-1:0]};
          grid_wd      = BLANK;
          fill_ptr_nxt = fill_ptr_r + 1'b1;
        end else begin
          grid_wa = {phys_r, cur_col_r[COL_W-1:0]};
          grid_wd = ch_r;
          if (fill_ptr_r == cur_col_r) begin
            rt_we      = 1'b1;
            rt_wa      = {bank_r, cur_row_r};
            rt_wd.phys = phys_r;
            rt_wd.hw   = col_inc;
          end
          state_nxt = ST_CELL_EV;
        end
      end

      ST_CELL_EV: begin
        evt_valid      = 1'b1;
        evt.event_kind = EV_CELL;
        evt.cell_col   = cur_col_r[COL_W-1:0];
        evt.cell_row   = cur_row_r;
        evt.cell_char  = ch_r;
        evt.cursor_col = col_inc;
        evt.cursor_row = cur_row_r;
        evt.last       = !tab_r || tab_done;
        if (evt_ready) begin
          cur_col_nxt = col_inc;
          if (tab_r && !tab_done) begin
            tab_cnt_nxt = tab_cnt_r + 1'b1;
            state_nxt   = ST_STORE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_RD_ROW: begin
        rd_hit_nxt = rd_hit;
        if (rd_hit) begin
          grid_re = 1'b1;
          grid_ra = {rt_rd_r.phys, rd_col_r};
        end
        state_nxt = ST_RD_CELL;
      end

      ST_RD_CELL: begin
        evt_valid      = 1'b1;
        evt.event_kind = EV_READ;
        evt.cell_col   = rd_col_r;
        evt.cell_row   = rd_row_r;
        evt.cell_char  = rd_hit_r ? grid_rd_r : BLANK;
        evt.cursor_col = cur_col_r;
        evt.cursor_row = cur_row_r;
        evt.last       = 1'b1;
        if (evt_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cur_col_r <= '0;
      cur_row_r <= '0;
      bank_r    <= 1'b0;
      clr_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      bank_r    <= bank_nxt;
      clr_r     <= clr_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ch_r         <= ch_nxt;
    tab_r        <= tab_nxt;
    tab_cnt_r    <= tab_cnt_nxt;
    cont_store_r <= cont_store_nxt;
    rd_col_r     <= rd_col_nxt;
    rd_row_r     <= rd_row_nxt;
    rd_hit_r     <= rd_hit_nxt;
    phys_r       <= phys_nxt;
    fill_ptr_r   <= fill_ptr_nxt;
    sweep_r      <= sweep_nxt;
  end

  // row table memory
  always_ff @(posedge clk) begin
    if (rt_we) begin
      rt_mem[rt_wa] <= rt_wd;
    end
    if (rt_re) begin
      rt_rd_r <= rt_mem[rt_ra];
    end
  end

  // grid memory
  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_wa] <= grid_wd;
    end
    if (grid_re) begin
      grid_rd_r <= grid_mem[grid_ra];
    end
  end

  // row table never read and written at one entry in the same cycle
  a_rt_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (rt_we && rt_re) |-> (rt_wa != rt_ra))
    else $error("row table read and write collide");

  // a finished sweep makes the new bank active
  a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && sweep_r[ROW_W]) |=> (bank_r != $past(bank_r)))
    else $error("bank not switched after scroll sweep");

  // an item is not finished after a result that is not its last
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (evt_valid && evt_ready && !evt.last) |=> (state_r != ST_IDLE))
    else $error("returned to idle after a result that is not the last");

  // a read leaves the cursor alone
  a_read_keeps_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_ROW) |=> ($stable(cur_col_r) && $stable(cur_row_r)))
    else $error("cursor moved during a read");

endmodule

@@ hw/rtl/text_console_cursor_engine.sv @@
// Text console cursor engine top level: config registers, sequencer, result register
`timescale 1ns / 1ps

// The console keeps a grid of up to 128 rows by 256 character cells and a
// cursor. Write commands print one byte (newline, carriage return,
// backspace and tab handled; other control bytes but NUL ignored) and give
// one item per stored cell and per scroll; read commands give one item
// with the stored cell. Rows are reached through a row table, so a scroll
// rewrites that table rather than moving characters: one sweep over all
// 128 entries, during which no item is taken. After reset the row table
// is initialized before the first item is accepted; configuration writes
// are taken at any time. A printable byte goes through the row table
// read, grid write and result in turn; a tab repeats these steps for
// each space written; a read goes through the row table read, grid read
// and result. Writing at a column beyond the written part of a row (only
// after a configuration change) blanks the gap first at one cell a cycle.
// The result register lets the next item start while a result waits.
module text_console_cursor_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  tcc_in_if.sink                           in_item,
  tcc_out_if.source                        out_item,
  input  logic                             cfg_we,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tcc_pkg::*;

  localparam logic [COL_W:0] COLS_LO = (COL_W + 1)'(TAB_STOP);
  localparam logic [COL_W:0] COLS_HI = (COL_W + 1)'(MAX_COLS);
  localparam logic [ROW_W:0] ROWS_HI = (ROW_W + 1)'(MAX_ROWS);

  logic [COL_W:0] columns_r, columns_nxt;
  logic [ROW_W:0] row_count_r, row_count_nxt;
  logic [ROW_W:0] scroll_chunk_r, scroll_chunk_nxt;
  cfg_t           cfg;

  item_t          item;
  logic           item_ready;
  logic           evt_valid;
  logic           evt_ready;
  evt_t           evt;

  logic           out_valid_r, out_valid_nxt;
  evt_t           out_evt_r;

  // configuration writes
  always_comb begin
    columns_nxt      = columns_r;
    row_count_nxt    = row_count_r;
    scroll_chunk_nxt = scroll_chunk_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS:      columns_nxt      = cfg_wdata;
        CFG_ROW_COUNT:    row_count_nxt    = cfg_wdata[ROW_W:0];
        CFG_SCROLL_CHUNK: scroll_chunk_nxt = cfg_wdata[ROW_W:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r      <= COLUMNS_RST;
      row_count_r    <= ROWS_RST;
      scroll_chunk_r <= CHUNK_RST;
    end else begin
      columns_r      <= columns_nxt;
      row_count_r    <= row_count_nxt;
      scroll_chunk_r <= scroll_chunk_nxt;
    end
  end

  // saturate registers to the usable ranges
  always_comb begin
    if (columns_r < COLS_LO) begin
      cfg.cols = COLS_LO;
    end else if (columns_r > COLS_HI) begin
      cfg.cols = COLS_HI;
    end else begin
      cfg.cols = columns_r;
    end
    if (row_count_r == '0) begin
      cfg.rows = (ROW_W + 1)'(1);
    end else if (row_count_r > ROWS_HI) begin
      cfg.rows = ROWS_HI;
    end else begin
      cfg.rows = row_count_r;
    end
    if (scroll_chunk_r == '0) begin
      cfg.chunk = (ROW_W + 1)'(1);
    end else if (scroll_chunk_r > cfg.rows) begin
      cfg.chunk = cfg.rows;
    end else begin
      cfg.chunk = scroll_chunk_r;
    end
  end

  // input item
  assign item.command   = in_item.command;
  assign item.data_byte = in_item.data_byte;
  assign item.read_col  = in_item.read_col;
  assign item.read_row  = in_item.read_row;
  assign in_item.ready  = item_ready;

  tcc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_item.valid),
    .item_ready (item_ready),
    .item       (item),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .evt        (evt)
  );

  // result register
  assign evt_ready = !out_valid_r || out_item.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (evt_valid && evt_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      out_evt_r <= evt;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.event_kind    = out_evt_r.event_kind;
  assign out_item.cell_col      = out_evt_r.cell_col;
  assign out_item.cell_row      = out_evt_r.cell_row;
  assign out_item.cell_char     = out_evt_r.cell_char;
  assign out_item.rows_scrolled = out_evt_r.rows_scrolled;
  assign out_item.cursor_col    = out_evt_r.cursor_col;
  assign out_item.cursor_row    = out_evt_r.cursor_row;
  assign out_item.last          = out_evt_r.last;

endmodule
